@@ hdl/fdre_pkg.sv @@
// Shared types, constants and helper functions for the fractional divider register encoder.
`default_nettype none

package fdre_pkg;

  localparam int unsigned IntW         = 12;
  localparam int unsigned FracW        = 20;
  localparam int unsigned FracShift    = 7;
  localparam int unsigned DqW          = FracW + FracShift;
  localparam int unsigned BitsPerStage = 3;
  localparam int unsigned DivStages    = DqW / BitsPerStage;
  localparam int unsigned P1W          = 18;
  localparam int unsigned BurstLen     = 9;
  localparam int unsigned IdxW         = 4;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(BurstLen - 1);

  localparam logic OpFeedback = 1'b0;
  localparam logic OpOutput   = 1'b1;

  localparam logic [7:0] AddrPllA = 8'h1A;
  localparam logic [7:0] AddrPllB = 8'h22;
  localparam logic [7:0] AddrMs0  = 8'h2A;
  localparam logic [7:0] AddrMs1  = 8'h32;
  localparam logic [7:0] AddrMs2  = 8'h3A;

  localparam logic [7:0]     DivBy4Bits = 8'h0C;
  localparam logic [P1W-1:0] P1Offset   = P1W'(512);
  localparam logic [IntW-1:0] QuarterInt = IntW'(4);

  // Burst byte positions
  localparam logic [IdxW-1:0] ByteAddr = 4'd0;
  localparam logic [IdxW-1:0] ByteP3Hi = 4'd1;
  localparam logic [IdxW-1:0] ByteP3Lo = 4'd2;
  localparam logic [IdxW-1:0] ByteP1Tp = 4'd3;
  localparam logic [IdxW-1:0] ByteP1Hi = 4'd4;
  localparam logic [IdxW-1:0] ByteP1Lo = 4'd5;
  localparam logic [IdxW-1:0] ByteMix  = 4'd6;
  localparam logic [IdxW-1:0] ByteP2Hi = 4'd7;
  localparam logic [IdxW-1:0] ByteP2Lo = 4'd8;

  // One request in flight through the divider.
  // dq holds the dividend bits still to consume at the top and quotient bits at the bottom.
  typedef struct packed {
    logic             opcode;
    logic [1:0]       unit;
    logic [IntW-1:0]  div_int;
    logic [FracW-1:0] div_den;
    logic [FracW-1:0] rem;
    logic [DqW-1:0]   dq;
  } fdre_stage_t;

  function automatic fdre_stage_t fdre_div_step(input fdre_stage_t s);
    fdre_stage_t    r;
    logic [FracW:0] trial;
    r = s;
    for (int i = 0; i < BitsPerStage; i++) begin
      trial = {r.rem, r.dq[DqW-1]};
      if (trial >= {1'b0, r.div_den}) begin
        r.rem = FracW'(trial - {1'b0, r.div_den});
        r.dq  = {r.dq[DqW-2:0], 1'b1};
      end else begin
        r.rem = trial[FracW-1:0];
        r.dq  = {r.dq[DqW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] fdre_start_addr(input logic opcode, input logic [1:0] unit);
    logic [7:0] a;
    if (opcode == OpFeedback) begin
      a = (unit == 2'd0) ? AddrPllA : AddrPllB;
    end else begin
      unique case (unit)
        2'd0:    a = AddrMs0;
        2'd1:    a = AddrMs1;
        default: a = AddrMs2;
      endcase
    end
    return a;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fractional_divider_register_encoder.sv @@
// Top level: pipelined divider feeding a nine-byte register burst serialiser.
// Each request steps through the divider stage registers; the first byte of its burst shows
// once the last of nine divider stages (three quotient bits each) feeds the burst register.
// One burst byte per cycle on the output while out_stall_i is low; while a burst is out,
// up to nine further requests are taken and held in the divider stages.
// Reset: stage valid bits, burst valid and the byte counter clear asynchronously.
`default_nettype none

module fractional_divider_register_encoder (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [1:0]                   unit_i,
  input  wire logic [fdre_pkg::IntW-1:0]    div_int_i,
  input  wire logic [fdre_pkg::FracW-1:0]   div_num_i,
  input  wire logic [fdre_pkg::FracW-1:0]   div_den_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic [fdre_pkg::IdxW-1:0]         byte_index_o,
  output logic                              last_o,
  output logic                              error_o
);
  import fdre_pkg::*;

  logic        stg_valid [DivStages+1];
  fdre_stage_t stg_data  [DivStages+1];
  logic        stg_stall [DivStages+1];

  assign stg_valid[0]         = in_valid_i;
  assign stg_data[0].opcode   = opcode_i;
  assign stg_data[0].unit     = unit_i;
  assign stg_data[0].div_int  = div_int_i;
  assign stg_data[0].div_den  = div_den_i;
  assign stg_data[0].rem      = '0;
  assign stg_data[0].dq       = {div_num_i, FracShift'(0)};
  assign in_stall_o           = stg_stall[0];

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    fdre_div_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (stg_valid[g]),
      .up_data_i  (stg_data[g]),
      .up_stall_o (stg_stall[g]),
      .dn_valid_o (stg_valid[g+1]),
      .dn_data_o  (stg_data[g+1]),
      .dn_stall_i (stg_stall[g+1])
    );
  end

  // Burst register
  logic             burst_valid_q;
  logic [IdxW-1:0]  idx_q;
  logic [P1W-1:0]   p1_q, p1_d;
  logic [FracW-1:0] p2_q, p2_d;
  logic [FracW-1:0] p3_q;
  logic [7:0]       addr_q;
  logic             quarter_q;
  logic             err_q, err_d;
  logic [DqW-1:0]   quo;
  logic             out_take, burst_done, load;
  fdre_stage_t      tail;

  assign tail       = stg_data[DivStages];
  assign out_take   = burst_valid_q && !out_stall_i;
  assign burst_done = out_take && (idx_q == IdxLast);
  assign stg_stall[DivStages] = burst_valid_q && !burst_done;
  assign load       = stg_valid[DivStages] && !stg_stall[DivStages];

  assign err_d = (tail.div_den == '0);
  assign quo   = err_d ? '0 : tail.dq;
  assign p2_d  = err_d ? '0 : tail.rem;
  // 128a + q - 512, kept to 18 bits
  assign p1_d  = P1W'({tail.div_int, FracShift'(0)}) + quo[P1W-1:0] - P1Offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_valid_q <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (load) begin
        burst_valid_q <= 1'b1;
        idx_q         <= '0;
      end else if (burst_done) begin
        burst_valid_q <= 1'b0;
        idx_q         <= '0;
      end else if (out_take) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      p3_q      <= tail.div_den;
      addr_q    <= fdre_start_addr(tail.opcode, tail.unit);
      quarter_q <= (tail.opcode == OpOutput) && (tail.div_int == QuarterInt);
      err_q     <= err_d;
    end
  end

  always_comb begin
    unique case (idx_q)
      ByteAddr: out_byte_o = addr_q;
      ByteP3Hi: out_byte_o = p3_q[15:8];
      ByteP3Lo: out_byte_o = p3_q[7:0];
      ByteP1Tp: out_byte_o = (quarter_q ? DivBy4Bits : 8'h00) | {6'd0, p1_q[17:16]};
      ByteP1Hi: out_byte_o = p1_q[15:8];
      ByteP1Lo: out_byte_o = p1_q[7:0];
      ByteMix:  out_byte_o = {p3_q[19:16], p2_q[19:16]};
      ByteP2Hi: out_byte_o = p2_q[15:8];
      ByteP2Lo: out_byte_o = p2_q[7:0];
      default:  out_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o  = burst_valid_q;
  assign byte_index_o = idx_q;
  assign last_o       = (idx_q == IdxLast);
  assign error_o      = err_q;

endmodule

`default_nettype wire

@@ hdl/fdre_div_stage.sv @@
// One register stage of the pipelined restoring divider.
`default_nettype none

module fdre_div_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 up_valid_i,
  input  wire fdre_pkg::fdre_stage_t up_data_i,
  output logic                      up_stall_o,
  output logic                      dn_valid_o,
  output fdre_pkg::fdre_stage_t     dn_data_o,
  input  wire logic                 dn_stall_i
);
  import fdre_pkg::*;

  logic        valid_q;
  fdre_stage_t data_q, data_d;

  assign up_stall_o = valid_q && dn_stall_i;
  assign data_d     = fdre_div_step(up_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!up_stall_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!up_stall_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/fdre_checker.sv @@
// Port-level checks for the fractional divider register encoder, bound to the top level.
`default_nettype none

module fdre_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_stall_i,
  input wire logic [7:0]                 out_byte_i,
  input wire logic [fdre_pkg::IdxW-1:0]  byte_index_i,
  input wire logic                       last_i,
  input wire logic                       error_i
);
  import fdre_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(byte_index_i) && $stable(error_i))
    else $error("stalled burst byte changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (byte_index_i == IdxLast)))
    else $error("last flag not on final burst byte");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !last_i |=> out_valid_i
      && (byte_index_i == $past(byte_index_i) + IdxW'(1)))
    else $error("burst byte skipped or broken off");

  a_err_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !last_i |=> error_i == $past(error_i))
    else $error("error flag changed within a burst");

  a_err_p3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i && (byte_index_i == ByteP3Hi || byte_index_i == ByteP3Lo)
      |-> out_byte_i == 8'h00)
    else $error("zero denominator burst carries non-zero P3");

endmodule

bind fractional_divider_register_encoder fdre_checker u_fdre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_i   (out_byte_o),
  .byte_index_i (byte_index_o),
  .last_i       (last_o),
  .error_i      (error_o)
);

`default_nettype wire

@@ tb/sv/fractional_divider_register_encoder_tb.sv @@
// Self-checking testbench for the fractional divider register encoder: bursts checked byte by byte.
`timescale 1ns / 100ps

module fractional_divider_register_encoder_tb;
  import fdre_pkg::*;

  typedef struct packed {
    logic             opcode;
    logic [1:0]       unit;
    logic [IntW-1:0]  div_int;
    logic [FracW-1:0] div_num;
    logic [FracW-1:0] div_den;
  } div_req_t;

  typedef struct packed {
    logic [7:0]      value;
    logic [IdxW-1:0] index;
    logic            is_last;
    logic            err;
  } burst_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             opcode = 1'b0;
  logic [1:0]       unit = '0;
  logic [IntW-1:0]  div_int = '0;
  logic [FracW-1:0] div_num = '0;
  logic [FracW-1:0] div_den = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic [IdxW-1:0]  byte_index;
  logic             last_flag;
  logic             err_flag;

  div_req_t    pending_reqs[$];
  burst_byte_t expected_bytes[$];
  int          reqs_accepted = 0;
  int          reqs_total = 0;
  int          mismatches = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  fractional_divider_register_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .unit_i       (unit),
    .div_int_i    (div_int),
    .div_num_i    (div_num),
    .div_den_i    (div_den),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .byte_index_o (byte_index),
    .last_o       (last_flag),
    .error_o      (err_flag)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Idling phases: receiver-heavy, then swapped to sender-heavy, then none
  assign send_idle_pct = (reqs_accepted < reqs_total / 3) ? 21 :
                         (reqs_accepted < 2 * reqs_total / 3) ? 56 : 0;
  assign recv_idle_pct = (reqs_accepted < reqs_total / 3) ? 56 :
                         (reqs_accepted < 2 * reqs_total / 3) ? 21 : 0;

  // Works out the nine bytes of the register burst for one divider request
  function automatic void encode_burst(input div_req_t r);
    logic [63:0]  quot;
    logic [63:0]  remainder;
    logic [P1W-1:0]   p1;
    logic [FracW-1:0] p2;
    logic [FracW-1:0] p3;
    logic [7:0]   addr;
    logic         quarter;
    logic         zero_den;
    logic [7:0]   bytes [BurstLen];
    burst_byte_t  b;
    quot = '0;
    remainder = '0;
    zero_den = (r.div_den == '0);
    if (!zero_den) begin
      quot = (64'(r.div_num) << 7) / 64'(r.div_den);
      remainder = (64'(r.div_num) << 7) - 64'(r.div_den) * quot;
    end
    p1 = P1W'((64'(r.div_int) << 7) + quot - 64'd512);
    p2 = remainder[FracW-1:0];
    p3 = r.div_den;
    if (r.opcode == OpFeedback) begin
      addr = (r.unit == 2'd0) ? AddrPllA : AddrPllB;
    end else begin
      addr = (r.unit == 2'd0) ? AddrMs0 : (r.unit == 2'd1) ? AddrMs1 : AddrMs2;
    end
    quarter = (r.opcode == OpOutput) && (r.div_int == 12'd4);
    bytes[0] = addr;
    bytes[1] = p3[15:8];
    bytes[2] = p3[7:0];
    bytes[3] = (quarter ? DivBy4Bits : 8'h00) | {6'd0, p1[17:16]};
    bytes[4] = p1[15:8];
    bytes[5] = p1[7:0];
    bytes[6] = {p3[19:16], p2[19:16]};
    bytes[7] = p2[15:8];
    bytes[8] = p2[7:0];
    for (int k = 0; k < BurstLen; k++) begin
      b.value   = bytes[k];
      b.index   = IdxW'(k);
      b.is_last = (IdxW'(k) == IdxLast);
      b.err     = zero_den;
      expected_bytes.push_back(b);
    end
  endfunction

  task automatic add_req(input logic op, input logic [1:0] u, input logic [IntW-1:0] a,
                         input logic [FracW-1:0] num, input logic [FracW-1:0] den);
    div_req_t r;
    r.opcode  = op;
    r.unit    = u;
    r.div_int = a;
    r.div_num = num;
    r.div_den = den;
    pending_reqs.push_back(r);
  endtask

  // Request driver: holds a stalled request, otherwise presents the next one or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      opcode   <= 1'b0;
      unit     <= '0;
      div_int  <= '0;
      div_num  <= '0;
      div_den  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_burst(pending_reqs.pop_front());
        reqs_accepted++;
      end
      if (in_valid && in_stall) begin
        // payload held
      end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        opcode   <= pending_reqs[0].opcode;
        unit     <= pending_reqs[0].unit;
        div_int  <= pending_reqs[0].div_int;
        div_num  <= pending_reqs[0].div_num;
        div_den  <= pending_reqs[0].div_den;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Burst monitor
  always @(posedge clk_i or negedge rst_ni) begin
    burst_byte_t exp_b;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected burst byte %02h at index %0d", out_byte, byte_index);
          mismatches++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte !== exp_b.value) begin
            $error("out_byte: expected %02h, got %02h", exp_b.value, out_byte);
            mismatches++;
          end
          if (byte_index !== exp_b.index) begin
            $error("byte_index: expected %0d, got %0d", exp_b.index, byte_index);
            mismatches++;
          end
          if (last_flag !== exp_b.is_last) begin
            $error("last: expected %0b, got %0b", exp_b.is_last, last_flag);
            mismatches++;
          end
          if (err_flag !== exp_b.err) begin
            $error("error: expected %0b, got %0b", exp_b.err, err_flag);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    logic [FracW-1:0] den;
    int sel;
    // zero denominator, with wrapping P1 on a small integer part
    add_req(OpFeedback, 2'd0, 12'd0, 20'd0, 20'd0);
    add_req(OpOutput, 2'd1, 12'd4095, 20'hFFFFF, 20'd0);
    add_req(OpOutput, 2'd0, 12'd4, 20'd5, 20'd0);
    // all address variants, output unit three included
    add_req(OpFeedback, 2'd1, 12'd36, 20'd1, 20'd3);
    add_req(OpFeedback, 2'd2, 12'd90, 20'd0, 20'd1);
    add_req(OpFeedback, 2'd3, 12'd15, 20'd7, 20'd11);
    add_req(OpOutput, 2'd0, 12'd8, 20'd999, 20'd1000);
    add_req(OpOutput, 2'd1, 12'd100, 20'd12345, 20'd54321);
    add_req(OpOutput, 2'd2, 12'd2048, 20'd1, 20'd2);
    add_req(OpOutput, 2'd3, 12'd50, 20'd3, 20'd7);
    // divide by four: only output dividers get the bits
    add_req(OpOutput, 2'd2, 12'd4, 20'd0, 20'd1);
    add_req(OpOutput, 2'd3, 12'd4, 20'hABCDE, 20'hFFFFF);
    add_req(OpFeedback, 2'd0, 12'd4, 20'd0, 20'd1);
    // numerator at or above denominator
    add_req(OpFeedback, 2'd1, 12'd20, 20'hFFFFF, 20'd1);
    add_req(OpOutput, 2'd0, 12'd30, 20'd777, 20'd777);
    add_req(OpOutput, 2'd1, 12'd4095, 20'hFFFFF, 20'd3);
    // extremes
    add_req(OpFeedback, 2'd0, 12'd0, 20'd0, 20'd1);
    add_req(OpFeedback, 2'd1, 12'd4095, 20'hFFFFF, 20'hFFFFF);
    add_req(OpOutput, 2'd2, 12'd2048, 20'hFFFFE, 20'hFFFFF);
    add_req(OpOutput, 2'd0, 12'd1, 20'h80000, 20'h80001);
    for (int i = 0; i < 350; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   IntW'($urandom_range(0, 4095)),
                   FracW'($urandom_range(0, 20'hFFFFF)), FracW'($urandom_range(0, 20'hFFFFF)));
        1: add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   IntW'($urandom_range(0, 4095)),
                   FracW'($urandom_range(0, 20'hFFFFF)), 20'd0);
        2: begin
          den = FracW'($urandom_range(1, 1000));
          add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  IntW'($urandom_range(0, 4095)),
                  FracW'($urandom_range(den, 20'hFFFFF)), den);
        end
        3: begin
          den = FracW'($urandom_range(1, 20'hFFFFF));
          add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 12'd4,
                  FracW'($urandom_range(0, den - 1)), den);
        end
        default: begin
          // plausible divider settings
          den = FracW'($urandom_range(1, 20'hFFFFF));
          add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  IntW'($urandom_range(6, 2048)),
                  FracW'($urandom_range(0, den - 1)), den);
        end
      endcase
    end
    reqs_total = pending_reqs.size();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (reqs_accepted < reqs_total) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
